FILE: hdl/csa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants, types and helpers for the compacted save-area layout unit.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int NUM_COMP = 61;
  localparam int IDX_W    = $clog2(NUM_COMP);
  localparam int CNUM_W   = 6;
  localparam int SIZE_W   = 16;
  localparam int SUM_W    = 22;
  localparam int ENTRY_W  = SIZE_W + 1;
  localparam int BMAP_W   = 64;

  localparam logic [CNUM_W-1:0] FIRST_COMP  = CNUM_W'(2);
  localparam logic [SUM_W-1:0]  PREFIX_SIZE = SUM_W'(576);
  localparam logic [SUM_W-1:0]  ALIGN_LOW   = SUM_W'(63);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
    logic en;
    logic below;
    logic at;
  } walk_ctl_t;

  function automatic logic [SUM_W-1:0] rnd64(input logic [SUM_W-1:0] v);
    rnd64 = (v + ALIGN_LOW) & ~ALIGN_LOW;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/csa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
  parameter int DEPTH = 61,
  parameter int WIDTH = 17
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/csa_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_walk
// Offset and total accumulators, advanced by one table entry per step.
// ----------------------------------------------------------------------------
module csa_walk
  import csa_pkg::*;
(
  input  wire logic              clk,
  input  wire walk_ctl_t         ctl,
  input  wire logic [SIZE_W-1:0] entry_size,
  input  wire logic              entry_align,
  output logic      [SUM_W-1:0]  offset,
  output logic      [SUM_W-1:0]  total
);

  logic [SUM_W-1:0] off_r, off_nxt;
  logic [SUM_W-1:0] tot_r, tot_nxt;
  logic [SUM_W-1:0] off_base, tot_base;

  always_comb begin
    off_base = entry_align ? rnd64(off_r) : off_r;
    tot_base = entry_align ? rnd64(tot_r) : tot_r;
    off_nxt  = off_r;
    tot_nxt  = tot_r;
    if (ctl.clear) begin
      off_nxt = '0;
      tot_nxt = PREFIX_SIZE;
    end else if (ctl.step) begin
      if (ctl.en) begin
        tot_nxt = tot_base + SUM_W'(entry_size);
      end
      if (ctl.below && ctl.en) begin
        off_nxt = off_base + SUM_W'(entry_size);
      end else if (ctl.at && entry_align) begin
        off_nxt = rnd64(off_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    tot_r <= tot_nxt;
  end

  assign offset = off_r;
  assign total  = tot_r;

endmodule
`default_nettype wire

FILE: hdl/compacted_save_area_offset_calc_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compacted_save_area_offset_calc_unit
// Compacted save-area layout: component table plus offset/size query walker.
// ----------------------------------------------------------------------------
// A load item writes one size/alignment entry into the component table (only
// for component numbers 2 to 62) and returns its result through the ST_DONE
// state and the output registers. A query item walks all 61 table entries
// through the table RAM, one entry per cycle: reads in ST_RUN, the RAM read
// latency in ST_DRAIN, then the result is registered from ST_DONE once the
// output register is free. The next item is accepted only after the result
// is registered. One item is in flight at a time; the RAM has no clearing
// pass, but valid bits cleared at reset make unloaded entries read as zero.
module compacted_save_area_offset_calc_unit
  import csa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [CNUM_W-1:0] in_component_number,
  input  wire logic [SIZE_W-1:0] in_entry_size,
  input  wire logic              in_entry_align64,
  input  wire logic [BMAP_W-1:0] in_enabled_bitmap,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [SUM_W-1:0]  out_component_offset,
  output logic      [SUM_W-1:0]  out_total_size,
  output logic      [SUM_W-1:0]  out_largest_size
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    rd_cnt_r;
  logic                pv_r;
  logic [IDX_W-1:0]    pi_r;
  logic [CNUM_W-1:0]   cnum_r;
  logic [BMAP_W-1:0]   bm_r;
  logic                op_r;
  logic [NUM_COMP-1:0] vld_r;
  logic                ent_vld_r;
  logic [SUM_W-1:0]    hw_r;
  logic                out_valid_r;
  logic [SUM_W-1:0]    out_off_r, out_tot_r, out_lg_r;

  logic                accept;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [ENTRY_W-1:0]  rd_data;
  logic [SIZE_W-1:0]   ent_size;
  logic                ent_align;
  logic [CNUM_W:0]     pos;
  logic [SUM_W-1:0]    walk_off, walk_tot, hw_new;
  logic                out_load;
  walk_ctl_t           ctl;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign wr_en  = accept && (in_opcode == OP_LOAD) && (in_component_number >= FIRST_COMP)
                  && ({1'b0, in_component_number} - {1'b0, FIRST_COMP} < (CNUM_W+1)'(NUM_COMP));
  assign wr_idx = IDX_W'(in_component_number - FIRST_COMP);

  csa_ram #(
    .DEPTH (NUM_COMP),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({in_entry_align64, in_entry_size}),
    .raddr (rd_cnt_r),
    .rdata (rd_data)
  );

  assign ent_size  = ent_vld_r ? rd_data[SIZE_W-1:0] : '0;
  assign ent_align = ent_vld_r && rd_data[SIZE_W];
  assign pos       = (CNUM_W+1)'(pi_r) + (CNUM_W+1)'(FIRST_COMP);

  always_comb begin
    ctl.clear = accept;
    ctl.step  = pv_r;
    ctl.en    = bm_r[pos[CNUM_W-1:0]];
    ctl.below = pos < {1'b0, cnum_r};
    ctl.at    = pos == {1'b0, cnum_r};
  end

  csa_walk u_walk (
    .clk         (clk),
    .ctl         (ctl),
    .entry_size  (ent_size),
    .entry_align (ent_align),
    .offset      (walk_off),
    .total       (walk_tot)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign hw_new   = (walk_tot > hw_r) ? walk_tot : hw_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_QUERY) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (rd_cnt_r == IDX_W'(NUM_COMP - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      vld_r       <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == ST_RUN);
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (op_r == OP_QUERY) begin
          hw_r <= hw_new;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_vld_r <= vld_r[rd_cnt_r];
    pi_r      <= rd_cnt_r;
    if (accept) begin
      rd_cnt_r <= '0;
      cnum_r   <= in_component_number;
      bm_r     <= in_enabled_bitmap;
      op_r     <= in_opcode;
    end else if ((state_r == ST_RUN) && (rd_cnt_r != IDX_W'(NUM_COMP - 1))) begin
      rd_cnt_r <= rd_cnt_r + IDX_W'(1);
    end
    if (out_load) begin
      if (op_r == OP_QUERY) begin
        out_off_r <= walk_off;
        out_tot_r <= walk_tot;
        out_lg_r  <= hw_new;
      end else begin
        out_off_r <= '0;
        out_tot_r <= '0;
        out_lg_r  <= hw_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_component_offset = out_off_r;
  assign out_total_size       = out_tot_r;
  assign out_largest_size     = out_lg_r;

endmodule
`default_nettype wire
